@@ rtl/adc_block_average_scale_delta_assert.svh @@
// Assertion macros for the block average decimator.
// Plain text only; included by adc_block_average_scale_delta, which checks its own logic.
`ifndef ADC_BLOCK_AVERAGE_SCALE_DELTA_ASSERT_SVH
`define ADC_BLOCK_AVERAGE_SCALE_DELTA_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ABASD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ABASD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/abasd_pkg.sv @@
// Package for the block average decimator: widths, register indexes and
// the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package abasd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_W     = 8;
  localparam int RES_W       = 16;
  localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
  localparam int PROD_W      = SAMPLE_BITS + RES_W;
  localparam int STEP_W      = $clog2(PROD_W + 1);
  localparam int VALUE_W     = 16;
  localparam int CHANGE_W    = 17;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_COUNT     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_RESOLUTION = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_MUL,
    ST_DIV_SCALE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/adc_block_average_scale_delta.sv @@
// A sample that completes a block starts the sequence: divide the sum by the sample count,
// multiply by output_resolution, divide by full scale, then emit the result beat; other
// samples are only added to the sum. No new sample is taken until the result is emitted,
// which waits for the result register to be free; the shared subtractor serves both divides.
// Reset (rst, synchronous) clears the sum, count and history and loads
// average_count = 1, output_resolution = 1023.
`timescale 1ns / 1ps

`include "adc_block_average_scale_delta_assert.svh"

module adc_block_average_scale_delta
  import abasd_pkg::*;
#(
  parameter int unsigned HW_FULL_SCALE = 1023
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [15:0] scaled_value, [32:16] change
);

  localparam int unsigned FULL_DIV = (HW_FULL_SCALE == 0) ? 1 : HW_FULL_SCALE;

  state_t state, state_next;

  logic [COUNT_W-1:0] average_count;
  logic [RES_W-1:0]   output_resolution;
  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] samples_taken;
  logic [VALUE_W-1:0] previous_value;
  logic               previous_known;

  logic [PROD_W-1:0]  quo;
  logic [RES_W-1:0]   rem;
  logic [RES_W-1:0]   divisor;
  logic [STEP_W-1:0]  step_cnt;

  logic               in_beat;
  logic               out_free;
  logic               div_step;
  logic               div_last;

  logic [SUM_W-1:0]   sum_new;
  logic [COUNT_W-1:0] taken_new;
  logic [COUNT_W-1:0] eff_count;
  logic               block_done;

  logic [RES_W:0]     rem_shift;
  logic [RES_W+1:0]   trial;
  logic               trial_ge;

  logic [VALUE_W-1:0] scaled;
  logic [CHANGE_W-1:0] change;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign sum_new    = sample_sum + SUM_W'(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign taken_new  = samples_taken + COUNT_W'(1);
  assign eff_count  = (average_count == '0) ? COUNT_W'(1) : average_count;
  assign block_done = taken_new >= eff_count;
  assign div_last   = step_cnt == STEP_W'(1);

  // shared restoring divide step
  assign rem_shift = {rem, quo[PROD_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, divisor};
  assign trial_ge  = !trial[RES_W+1];

  assign scaled = (|quo[PROD_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : quo[VALUE_W-1:0];
  assign change = previous_known ?
                  ({1'b0, scaled} - {1'b0, previous_value}) : '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat && block_done) state_next = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_last) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV_SCALE;
      end
      ST_DIV_SCALE: begin
        if (div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_step      = 1'b0;
    case (state)
      ST_IDLE:      s_axis_tready = 1'b1;
      ST_DIV_AVG:   div_step = 1'b1;
      ST_DIV_SCALE: div_step = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        div_step      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      average_count     <= COUNT_W'(1);
      output_resolution <= RES_W'(1023);
      sample_sum        <= '0;
      samples_taken     <= '0;
      previous_value    <= '0;
      previous_known    <= 1'b0;
      step_cnt          <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_AVERAGE_COUNT:     average_count     <= cfg_data[COUNT_W-1:0];
          REG_OUTPUT_RESOLUTION: output_resolution <= cfg_data[RES_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (block_done) begin
              sample_sum    <= '0;
              samples_taken <= '0;
              step_cnt      <= STEP_W'(SUM_W);
            end else begin
              sample_sum    <= sum_new;
              samples_taken <= taken_new;
            end
          end
        end
        ST_DIV_AVG, ST_DIV_SCALE: begin
          step_cnt <= step_cnt - STEP_W'(1);
        end
        ST_MUL: begin
          step_cnt <= STEP_W'(PROD_W);
        end
        ST_EMIT: begin
          if (out_free) begin
            previous_value <= scaled;
            previous_known <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath: no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_beat && block_done) begin
      quo     <= {sum_new, {(PROD_W - SUM_W){1'b0}}};
      rem     <= '0;
      divisor <= RES_W'(taken_new);
    end else if (div_step) begin
      quo     <= {quo[PROD_W-2:0], trial_ge};
      rem     <= trial_ge ? trial[RES_W-1:0] : rem_shift[RES_W-1:0];
    end else if (state == ST_MUL) begin
      quo     <= {{RES_W{1'b0}}, quo[SAMPLE_BITS-1:0]} *
                 {{SAMPLE_BITS{1'b0}}, output_resolution};
      rem     <= '0;
      divisor <= RES_W'(FULL_DIV);
    end
    if (state == ST_EMIT && out_free) begin
      m_axis_tdata <= {{(OUT_DATA_W - VALUE_W - CHANGE_W){1'b0}}, change, scaled};
    end
  end

  `ABASD_ASSERT_NOW(a_step_count_live, clk, rst,
    (state == ST_DIV_AVG || state == ST_DIV_SCALE), (step_cnt != '0),
    "divide step counter ran out inside a divide")
  `ABASD_ASSERT_NOW(a_rem_below_divisor, clk, rst,
    (state == ST_DIV_AVG || state == ST_DIV_SCALE), (rem < divisor),
    "partial remainder not below divisor")
  `ABASD_ASSERT_NOW(a_avg_fits, clk, rst,
    (state == ST_MUL), (quo[PROD_W-1:SAMPLE_BITS] == '0),
    "block average wider than a sample")
  `ABASD_ASSERT_NEXT(a_emit_gives_beat, clk, rst,
    (state == ST_EMIT && out_free), (m_axis_tvalid && state == ST_IDLE),
    "emit did not present a result beat")

endmodule
